>>> rtl/wsts_pkg.sv
// Package for the work-stealing task scheduler: shared types and codes.
// No dependencies.
package wsts_pkg;

   typedef enum logic [1:0] {
      MODE_WORKER_SCHED = 2'd0,
      MODE_OUTSIDE_SCHED = 2'd1,
      MODE_REQUEST = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      SRC_OWN = 2'd0,
      SRC_GLOBAL = 2'd1,
      SRC_STOLEN = 2'd2,
      SRC_NONE = 2'd3
   } source_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN,
      ST_READ,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      RSEL_NONE = 2'd0,
      RSEL_DEQUE = 2'd1,
      RSEL_GLOBAL = 2'd2
   } rsel_type;

   localparam int unsigned MODE_BITS = 2;
   localparam int unsigned WIDX_BITS = 3;
   localparam int unsigned TASK_PORT_BITS = 16;
   localparam int unsigned CNT_REG_BITS = 4;
   localparam int unsigned WORKER_COUNT_RESET = 8;

endpackage

>>> rtl/wsts_ram.sv
// Single-port task store with a registered read.
// Depends on nothing.
module wsts_ram #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

>>> rtl/work_stealing_task_scheduler.sv
// Top level of the work-stealing task scheduler: sequencer, pointers, stores.
// Depends on wsts_pkg and wsts_ram.
//
// Command-style block. Raise start with mode, worker and task_req while busy
// is low; busy then stays high through the cycle in which the one result per
// item appears on the rsp_ ports, marked by rsp_valid. The receiver cannot
// stall. A schedule or own-deque/global request steps through DECIDE, READ
// and DONE, with the strobe in DONE; a steal adds a SCAN state between
// DECIDE and READ that scans worker indices counting up from 0, the
// requester's own index included, below the clamped active worker count,
// as one shared compare unit walks the per-worker deque counts in order. The
// deque and global stores are single-port RAMs with registered reads. Stores
// need no clearing: only filled slots are read. Write csr_wr_en/csr_wr_data
// (worker_count) only while busy is low.
module work_stealing_task_scheduler
   import wsts_pkg::*;
#(
   parameter int unsigned WORKERS = 8,
   parameter int unsigned LOCAL_DEPTH = 256,
   parameter int unsigned GLOBAL_DEPTH = 1024,
   parameter int unsigned TASK_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [MODE_BITS-1:0]      req_mode,
   input  logic [WIDX_BITS-1:0]      req_worker,
   input  logic [TASK_PORT_BITS-1:0] req_task_req,
   output logic                      rsp_valid,
   output logic                      rsp_got_task,
   output logic [TASK_PORT_BITS-1:0] rsp_task_out,
   output logic [1:0]                rsp_source,
   output logic [WIDX_BITS-1:0]      rsp_victim,
   output logic                      rsp_dropped,
   input  logic                      csr_wr_en,
   input  logic [CNT_REG_BITS-1:0]   csr_wr_data
);
   localparam int unsigned WB = (WORKERS > 1) ? $clog2(WORKERS) : 1;
   localparam int unsigned WCB = $clog2(WORKERS + 1);
   localparam int unsigned LB = $clog2(LOCAL_DEPTH);
   localparam int unsigned GB = $clog2(GLOBAL_DEPTH);
   localparam int unsigned GCB = $clog2(GLOBAL_DEPTH + 1);
   localparam int unsigned DB = WB + LB;
   localparam int unsigned XB = (WIDX_BITS > WCB) ? WIDX_BITS : WCB;

   state_type state_ff, state_in;

   logic [CNT_REG_BITS-1:0] wcount_ff;
   logic [LB-1:0] head_ff [WORKERS];
   logic [LB-1:0] tail_ff [WORKERS];
   logic [GB-1:0] grd_ff, gwr_ff;
   logic [GCB-1:0] gcnt_ff;

   // latched item
   mode_type mode_ff;
   logic [WIDX_BITS-1:0] worker_ff;
   logic [TASK_BITS-1:0] task_ff;
   logic [WB-1:0] scan_ff, scan_in;
   logic [WCB-1:0] act_ff;
   logic own_ff;

   // result
   logic got_ff;
   source_type src_ff;
   logic [WIDX_BITS-1:0] vic_ff;
   logic drop_ff;
   rsel_type rsel_ff; // which store feeds task_out

   logic d_we, g_we;
   logic [DB-1:0] d_addr;
   logic [GB-1:0] g_addr;
   logic [TASK_BITS-1:0] d_rd, g_rd;

   wsts_ram #(.DEPTH(WORKERS * LOCAL_DEPTH), .WIDTH(TASK_BITS)) u_deque (
      .clock(clock), .wr_en(d_we), .addr(d_addr), .wr_data(task_ff), .rd_data(d_rd)
   );
   wsts_ram #(.DEPTH(GLOBAL_DEPTH), .WIDTH(TASK_BITS)) u_global (
      .clock(clock), .wr_en(g_we), .addr(g_addr), .wr_data(task_ff), .rd_data(g_rd)
   );

   // active workers, clamped
   logic [WCB-1:0] act_now;
   always_comb begin
      if (wcount_ff == '0) begin
         act_now = WCB'(1);
      end else if (32'(wcount_ff) > WORKERS) begin
         act_now = WCB'(WORKERS);
      end else begin
         act_now = WCB'(wcount_ff);
      end
   end

   logic [WB-1:0] wsel;
   assign wsel = WB'(worker_ff);
   logic own_cnt_nz, own_cnt_full;
   logic [LB-1:0] own_cnt;
   assign own_cnt = head_ff[wsel] - tail_ff[wsel];
   assign own_cnt_nz = (own_cnt != '0);
   assign own_cnt_full = (own_cnt == LB'(LOCAL_DEPTH - 1));
   logic gfull, gempty;
   assign gfull = (gcnt_ff == GCB'(GLOBAL_DEPTH));
   assign gempty = (gcnt_ff == '0);

   // shared scan compare: is the scanned worker a valid victim
   logic scan_hit, scan_last;
   assign scan_hit = (head_ff[scan_ff] != tail_ff[scan_ff])
                     && (XB'(scan_ff) != XB'(worker_ff));
   assign scan_last = (WCB'(scan_ff) + WCB'(1) >= act_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (start) state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (mode_ff == MODE_REQUEST && !(own_ff && own_cnt_nz) && gempty) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_SCAN: if (scan_hit || scan_last) state_in = ST_READ;
         ST_READ: state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // memory control
   always_comb begin
      d_we = 1'b0;
      g_we = 1'b0;
      d_addr = {wsel, head_ff[wsel]};
      g_addr = gwr_ff;
      if (state_ff == ST_DECIDE) begin
         case (mode_ff)
            MODE_WORKER_SCHED, MODE_OUTSIDE_SCHED: begin
               if (mode_ff == MODE_WORKER_SCHED && own_ff && !own_cnt_full) begin
                  d_we = 1'b1;
               end else begin
                  g_we = !gfull;
               end
            end
            MODE_REQUEST: begin
               d_addr = {wsel, head_ff[wsel] - LB'(1)};
               g_addr = grd_ff;
            end
            default: ;
         endcase
      end else if (state_ff == ST_SCAN) begin
         d_addr = {scan_ff, tail_ff[scan_ff]};
      end
   end

   assign scan_in = (state_ff == ST_SCAN) ? scan_ff + WB'(1) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wcount_ff <= CNT_REG_BITS'(WORKER_COUNT_RESET);
         grd_ff <= '0;
         gwr_ff <= '0;
         gcnt_ff <= '0;
         for (int i = 0; i < WORKERS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) wcount_ff <= csr_wr_data;
         if (state_ff == ST_DECIDE) begin
            if (d_we) head_ff[wsel] <= head_ff[wsel] + LB'(1);
            if (g_we) begin
               gwr_ff <= gwr_ff + GB'(1);
               gcnt_ff <= gcnt_ff + GCB'(1);
            end
            if (mode_ff == MODE_REQUEST) begin
               if (own_ff && own_cnt_nz) begin
                  head_ff[wsel] <= head_ff[wsel] - LB'(1);
               end else if (!gempty) begin
                  grd_ff <= grd_ff + GB'(1);
                  gcnt_ff <= gcnt_ff - GCB'(1);
               end
            end
         end
         if (state_ff == ST_SCAN && scan_hit) begin
            tail_ff[scan_ff] <= tail_ff[scan_ff] + LB'(1);
         end
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         mode_ff <= mode_type'(req_mode);
         worker_ff <= req_worker;
         task_ff <= TASK_BITS'(req_task_req);
         act_ff <= act_now;
         own_ff <= (XB'(req_worker) < XB'(act_now));
         got_ff <= 1'b0;
         src_ff <= SRC_NONE;
         vic_ff <= '0;
         drop_ff <= 1'b0;
         rsel_ff <= RSEL_NONE;
      end
      scan_ff <= scan_in;
      if (state_ff == ST_DECIDE) begin
         if ((mode_ff == MODE_WORKER_SCHED || mode_ff == MODE_OUTSIDE_SCHED)
             && !d_we && gfull) begin
            drop_ff <= 1'b1;
         end
         if (mode_ff == MODE_REQUEST) begin
            if (own_ff && own_cnt_nz) begin
               got_ff <= 1'b1; src_ff <= SRC_OWN; rsel_ff <= RSEL_DEQUE;
            end else if (!gempty) begin
               got_ff <= 1'b1; src_ff <= SRC_GLOBAL; rsel_ff <= RSEL_GLOBAL;
            end
         end
      end
      if (state_ff == ST_SCAN && scan_hit) begin
         got_ff <= 1'b1;
         src_ff <= SRC_STOLEN;
         vic_ff <= WIDX_BITS'(scan_ff);
         rsel_ff <= RSEL_DEQUE;
      end
   end

   // output register
   logic rsp_valid_ff;
   logic [TASK_PORT_BITS-1:0] task_out_ff;
   logic [TASK_BITS-1:0] rd_sel;
   always_comb begin
      case (rsel_ff)
         RSEL_DEQUE: rd_sel = d_rd;
         RSEL_GLOBAL: rd_sel = g_rd;
         default: rd_sel = '0;
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_READ);
      end
      if (state_ff == ST_READ) begin
         task_out_ff <= TASK_PORT_BITS'(rd_sel);
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_got_task = got_ff;
   assign rsp_task_out = task_out_ff;
   assign rsp_source = src_ff;
   assign rsp_victim = vic_ff;
   assign rsp_dropped = drop_ff;
endmodule

>>> rtl/wsts_checker.sv
// Port-level checker for the work-stealing task scheduler, bound to the top.
// Depends on wsts_pkg.
module wsts_checker
   import wsts_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_valid,
   input logic                      rsp_got_task,
   input logic [1:0]                rsp_source,
   input logic [WIDX_BITS-1:0]      rsp_victim,
   input logic                      rsp_dropped
);
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("start not taken");
   a_strobe_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after strobe");
   a_got_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_got_task == (rsp_source != SRC_NONE)))
      else $error("got/source mismatch");
   a_drop_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> !rsp_got_task) else $error("drop with task");
   a_victim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_source != SRC_STOLEN |-> rsp_victim == '0)
      else $error("victim without steal");
endmodule

bind work_stealing_task_scheduler wsts_checker u_wsts_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_got_task(rsp_got_task), .rsp_source(rsp_source),
   .rsp_victim(rsp_victim), .rsp_dropped(rsp_dropped)
);
